### rtl/core/fdd_pkg.sv
// Shared types and constants for the finite difference derivative block.
package fdd_pkg;

   localparam int DATA_WIDTH    = 32;
   localparam int FRACTION_BITS = 16;
   // difference of two data words, one bit wider
   localparam int DIFF_W        = DATA_WIDTH + 1;
   // scaled numerator magnitude, later the quotient
   localparam int NUM_W         = DIFF_W + FRACTION_BITS;
   // partial remainder after its left shift
   localparam int REM_W         = DIFF_W + 1;
   localparam int ITER_W        = $clog2(NUM_W);
   // quotient bits from the sign position upward
   localparam int HI_W          = NUM_W - DATA_WIDTH + 1;

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   localparam data_type DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam data_type DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_FINISH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      data_type slope;
      logic     error;
      logic     saturated;
      logic     end_of_run;
   } result_type;

endpackage

### rtl/core/fdd_if.sv
// Request and response stream interfaces of the finite difference derivative block.
interface fdd_req_if;
   logic              valid;
   logic              ready;
   fdd_pkg::data_type x_value;
   fdd_pkg::data_type f_value;
   logic              is_last;

   modport source (output valid, output x_value, output f_value, output is_last,
                   input ready);
   modport sink   (input valid, input x_value, input f_value, input is_last,
                   output ready);
endinterface

interface fdd_rsp_if;
   logic              valid;
   logic              ready;
   fdd_pkg::data_type slope;
   logic              error;
   logic              saturated;
   logic              end_of_run;

   modport source (output valid, output slope, output error, output saturated,
                   output end_of_run, input ready);
   modport sink   (input valid, input slope, input error, input saturated,
                   input end_of_run, output ready);
endinterface

### rtl/core/finite_difference_derivative.sv
// Streaming first derivative of a tabulated function using one shared restoring divider.
// A chord request passes through setup, the restoring divide steps, saturation and the
// output load; a zero-width chord skips from setup to the output load, flagged as an error.
// A last point then adds a backward chord. Req ready is high only while idle, so a new point
// is taken only once the chords of the previous one are loaded, which waits on rsp ready.
// Reset (synchronous, active high) clears the sequencer, the point count and rsp valid.
module finite_difference_derivative (
   input  logic      clock,
   input  logic      reset,
   fdd_req_if.sink   req_if,
   fdd_rsp_if.source rsp_if
);

   fdd_pkg::state_type  state_ff, state_in;
   fdd_pkg::data_type   older_x_ff, older_x_in, older_f_ff, older_f_in;
   fdd_pkg::data_type   newer_x_ff, newer_x_in, newer_f_ff, newer_f_in;
   fdd_pkg::data_type   op0_x_ff, op0_x_in, op0_f_ff, op0_f_in;
   fdd_pkg::data_type   op1_x_ff, op1_x_in, op1_f_ff, op1_f_in;
   logic [1:0]          points_seen_ff, points_seen_in;
   logic                second_ff, second_in;
   logic                chord_end_ff, chord_end_in;
   logic                neg_ff, neg_in;
   logic [fdd_pkg::NUM_W-1:0]  num_ff, num_in;
   logic [fdd_pkg::DIFF_W-1:0] den_ff, den_in;
   logic [fdd_pkg::DIFF_W-1:0] rem_ff, rem_in;
   logic [fdd_pkg::ITER_W-1:0] count_ff, count_in;
   fdd_pkg::result_type res_ff, res_in;
   fdd_pkg::result_type rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                       accept_w;
   logic                       out_free_w;
   logic [fdd_pkg::DIFF_W-1:0] dx_w, df_w, dx_mag_w, df_mag_w;
   logic [fdd_pkg::REM_W-1:0]  rem_sh_w, rem_sub_w;
   logic                       ge_w;
   logic [fdd_pkg::HI_W-1:0]   hi_w;
   logic                       over_w;
   fdd_pkg::data_type          mag_w;

   assign req_if.ready = (state_ff == fdd_pkg::ST_IDLE);
   assign accept_w     = req_if.valid && req_if.ready;
   assign out_free_w   = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.slope      = rsp_ff.slope;
   assign rsp_if.error      = rsp_ff.error;
   assign rsp_if.saturated  = rsp_ff.saturated;
   assign rsp_if.end_of_run = rsp_ff.end_of_run;

   // chord differences and magnitudes
   always_comb begin
      dx_w     = {op1_x_ff[fdd_pkg::DATA_WIDTH-1], op1_x_ff}
               - {op0_x_ff[fdd_pkg::DATA_WIDTH-1], op0_x_ff};
      df_w     = {op1_f_ff[fdd_pkg::DATA_WIDTH-1], op1_f_ff}
               - {op0_f_ff[fdd_pkg::DATA_WIDTH-1], op0_f_ff};
      dx_mag_w = dx_w[fdd_pkg::DIFF_W-1] ? (fdd_pkg::DIFF_W'(0) - dx_w) : dx_w;
      df_mag_w = df_w[fdd_pkg::DIFF_W-1] ? (fdd_pkg::DIFF_W'(0) - df_w) : df_w;
   end

   // one restoring divide step
   always_comb begin
      rem_sh_w  = {rem_ff, num_ff[fdd_pkg::NUM_W-1]};
      ge_w      = rem_sh_w >= {1'b0, den_ff};
      rem_sub_w = rem_sh_w - {1'b0, den_ff};
   end

   // saturate the finished quotient
   always_comb begin
      hi_w   = num_ff[fdd_pkg::NUM_W-1:fdd_pkg::DATA_WIDTH-1];
      over_w = neg_ff
             ? ((hi_w != '0) && !((hi_w == fdd_pkg::HI_W'(1)) &&
                                  (num_ff[fdd_pkg::DATA_WIDTH-2:0] == '0)))
             : (hi_w != '0);
      mag_w  = num_ff[fdd_pkg::DATA_WIDTH-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fdd_pkg::ST_IDLE: begin
            if (accept_w) begin
               if (points_seen_ff == 2'd0) begin
                  state_in = req_if.is_last ? fdd_pkg::ST_EMIT : fdd_pkg::ST_IDLE;
               end else begin
                  state_in = fdd_pkg::ST_SETUP;
               end
            end
         end
         fdd_pkg::ST_SETUP: begin
            state_in = (dx_mag_w == '0) ? fdd_pkg::ST_EMIT : fdd_pkg::ST_DIVIDE;
         end
         fdd_pkg::ST_DIVIDE: begin
            if (count_ff == '0) begin
               state_in = fdd_pkg::ST_FINISH;
            end
         end
         fdd_pkg::ST_FINISH: begin
            state_in = fdd_pkg::ST_EMIT;
         end
         fdd_pkg::ST_EMIT: begin
            if (out_free_w) begin
               state_in = second_ff ? fdd_pkg::ST_SETUP : fdd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fdd_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      older_x_in     = older_x_ff;
      older_f_in     = older_f_ff;
      newer_x_in     = newer_x_ff;
      newer_f_in     = newer_f_ff;
      op0_x_in       = op0_x_ff;
      op0_f_in       = op0_f_ff;
      op1_x_in       = op1_x_ff;
      op1_f_in       = op1_f_ff;
      points_seen_in = points_seen_ff;
      second_in      = second_ff;
      chord_end_in   = chord_end_ff;
      neg_in         = neg_ff;
      num_in         = num_ff;
      den_in         = den_ff;
      rem_in         = rem_ff;
      count_in       = count_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;

      case (state_ff)
         fdd_pkg::ST_IDLE: begin
            if (accept_w) begin
               if (points_seen_ff == 2'd0) begin
                  if (req_if.is_last) begin
                     // run of one point
                     res_in    = '{slope: '0, error: 1'b1, saturated: 1'b0,
                                   end_of_run: 1'b1};
                     second_in = 1'b0;
                  end else begin
                     newer_x_in     = req_if.x_value;
                     newer_f_in     = req_if.f_value;
                     points_seen_in = 2'd1;
                  end
               end else begin
                  // forward difference for the second point, central after that
                  op0_x_in       = (points_seen_ff == 2'd1) ? newer_x_ff : older_x_ff;
                  op0_f_in       = (points_seen_ff == 2'd1) ? newer_f_ff : older_f_ff;
                  op1_x_in       = req_if.x_value;
                  op1_f_in       = req_if.f_value;
                  older_x_in     = newer_x_ff;
                  older_f_in     = newer_f_ff;
                  newer_x_in     = req_if.x_value;
                  newer_f_in     = req_if.f_value;
                  points_seen_in = req_if.is_last ? 2'd0 : 2'd2;
                  second_in      = req_if.is_last;
                  chord_end_in   = 1'b0;
               end
            end
         end
         fdd_pkg::ST_SETUP: begin
            if (dx_mag_w == '0) begin
               res_in = '{slope: '0, error: 1'b1, saturated: 1'b0,
                          end_of_run: chord_end_ff};
            end else begin
               num_in   = fdd_pkg::NUM_W'(df_mag_w) << fdd_pkg::FRACTION_BITS;
               den_in   = dx_mag_w;
               rem_in   = '0;
               count_in = fdd_pkg::ITER_W'(fdd_pkg::NUM_W - 1);
               neg_in   = dx_w[fdd_pkg::DIFF_W-1] ^ df_w[fdd_pkg::DIFF_W-1];
            end
         end
         fdd_pkg::ST_DIVIDE: begin
            // shift quotient bits in where numerator bits leave
            rem_in   = ge_w ? rem_sub_w[fdd_pkg::DIFF_W-1:0]
                            : rem_sh_w[fdd_pkg::DIFF_W-1:0];
            num_in   = {num_ff[fdd_pkg::NUM_W-2:0], ge_w};
            count_in = count_ff - 1'b1;
         end
         fdd_pkg::ST_FINISH: begin
            res_in.error      = 1'b0;
            res_in.saturated  = over_w;
            res_in.end_of_run = chord_end_ff;
            if (over_w) begin
               res_in.slope = neg_ff ? fdd_pkg::DATA_MIN : fdd_pkg::DATA_MAX;
            end else begin
               res_in.slope = neg_ff ? (fdd_pkg::data_type'(0) - mag_w) : mag_w;
            end
         end
         fdd_pkg::ST_EMIT: begin
            if (out_free_w) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               if (second_ff) begin
                  // backward difference over the last two points
                  op0_x_in     = older_x_ff;
                  op0_f_in     = older_f_ff;
                  op1_x_in     = newer_x_ff;
                  op1_f_in     = newer_f_ff;
                  second_in    = 1'b0;
                  chord_end_in = 1'b1;
               end
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= fdd_pkg::ST_IDLE;
         points_seen_ff <= 2'd0;
         second_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         older_x_ff     <= '0;
         older_f_ff     <= '0;
         newer_x_ff     <= '0;
         newer_f_ff     <= '0;
      end else begin
         state_ff       <= state_in;
         points_seen_ff <= points_seen_in;
         second_ff      <= second_in;
         rsp_valid_ff   <= rsp_valid_in;
         older_x_ff     <= older_x_in;
         older_f_ff     <= older_f_in;
         newer_x_ff     <= newer_x_in;
         newer_f_ff     <= newer_f_in;
      end
   end

   always_ff @(posedge clock) begin
      op0_x_ff     <= op0_x_in;
      op0_f_ff     <= op0_f_in;
      op1_x_ff     <= op1_x_in;
      op1_f_ff     <= op1_f_in;
      chord_end_ff <= chord_end_in;
      neg_ff       <= neg_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      count_ff     <= count_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   a_err_zero_slope: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.error |-> (rsp_if.slope == '0) && !rsp_if.saturated)
      else $error("error response with nonzero slope or saturation");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == fdd_pkg::ST_DIVIDE |-> den_ff != '0)
      else $error("divide running with zero divisor");

   a_points_range: assert property (@(posedge clock) disable iff (reset)
      points_seen_ff != 2'd3)
      else $error("point count out of range");

   a_second_run_closed: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> points_seen_ff == 2'd0)
      else $error("pending backward difference while run still open");

endmodule

### tb/sv/tb_finite_difference_derivative.sv
// Self-checking stream testbench for the finite difference derivative block.
module tb_finite_difference_derivative;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_POINTS = 1750;
   localparam int TAIL_POINTS   = 150;
   localparam int SETTLE_CYCLES = 150;
   localparam int PRINT_CAP     = 50;
   localparam fdd_pkg::data_type ONE = 32'sh0001_0000;

   typedef enum logic [1:0] {
      SEND_POINT,
      SEND_GAP,
      SEND_DRAIN
   } send_kind_type;

   typedef struct packed {
      send_kind_type     kind;
      fdd_pkg::data_type x_value;
      fdd_pkg::data_type f_value;
      logic              is_last;
   } send_entry_type;

   logic clock;
   logic reset;

   fdd_req_if req_if ();
   fdd_rsp_if rsp_if ();

   finite_difference_derivative dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   send_entry_type      point_queue[$];
   fdd_pkg::result_type slope_queue[$];
   send_entry_type      head;

   // predictor state: the two points held back and how many of the run are in
   fdd_pkg::data_type back_x, back_f, near_x, near_f;
   int       run_len;

   int points_built, runs_built, points_sent;
   int slopes_checked, flagged_count, clipped_count, fail_count;
   int stall_left, monitor_cycles;
   int stall_pct = 10;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(string msg);
      if (fail_count < PRINT_CAP)
         $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // chord slope (f1-f0)/(x1-x0) scaled by 2^FRACTION_BITS, truncated, clipped
   function automatic fdd_pkg::result_type chord_slope(fdd_pkg::data_type x0,
                                                       fdd_pkg::data_type f0,
                                                       fdd_pkg::data_type x1,
                                                       fdd_pkg::data_type f1,
                                                       logic at_end);
      logic signed [fdd_pkg::DIFF_W-1:0] df, dx;
      logic [63:0]                       num_mag, den_mag, quot, limit;
      logic                              neg;
      fdd_pkg::result_type               r;
      df = {f1[fdd_pkg::DATA_WIDTH-1], f1} - {f0[fdd_pkg::DATA_WIDTH-1], f0};
      dx = {x1[fdd_pkg::DATA_WIDTH-1], x1} - {x0[fdd_pkg::DATA_WIDTH-1], x0};
      r.slope      = '0;
      r.error      = 1'b0;
      r.saturated  = 1'b0;
      r.end_of_run = at_end;
      if (dx == 0) begin
         r.error = 1'b1;
      end else begin
         num_mag = {{(64-fdd_pkg::DIFF_W){1'b0}}, (df[fdd_pkg::DIFF_W-1] ? -df : df)};
         den_mag = {{(64-fdd_pkg::DIFF_W){1'b0}}, (dx[fdd_pkg::DIFF_W-1] ? -dx : dx)};
         quot    = (num_mag << fdd_pkg::FRACTION_BITS) / den_mag;
         neg     = df[fdd_pkg::DIFF_W-1] ^ dx[fdd_pkg::DIFF_W-1];
         limit   = neg ? (64'd1 << (fdd_pkg::DATA_WIDTH-1))
                       : (64'd1 << (fdd_pkg::DATA_WIDTH-1)) - 64'd1;
         if (quot > limit) begin
            r.saturated = 1'b1;
            r.slope     = neg ? fdd_pkg::DATA_MIN : fdd_pkg::DATA_MAX;
         end else begin
            r.slope = neg ? -quot[fdd_pkg::DATA_WIDTH-1:0] : quot[fdd_pkg::DATA_WIDTH-1:0];
         end
      end
      return r;
   endfunction

   task automatic take_point(fdd_pkg::data_type x, fdd_pkg::data_type f, logic last);
      fdd_pkg::result_type lone;
      if (run_len == 0) begin
         if (last) begin
            lone.slope      = '0;
            lone.error      = 1'b1;
            lone.saturated  = 1'b0;
            lone.end_of_run = 1'b1;
            slope_queue.push_back(lone);
         end else begin
            near_x  = x;
            near_f  = f;
            run_len = 1;
         end
      end else begin
         if (run_len == 1)
            slope_queue.push_back(chord_slope(near_x, near_f, x, f, 1'b0));
         else
            slope_queue.push_back(chord_slope(back_x, back_f, x, f, 1'b0));
         back_x  = near_x;
         back_f  = near_f;
         near_x  = x;
         near_f  = f;
         run_len = 2;
         if (last) begin
            slope_queue.push_back(chord_slope(back_x, back_f, near_x, near_f, 1'b1));
            run_len = 0;
         end
      end
   endtask

   task automatic add_point(fdd_pkg::data_type x, fdd_pkg::data_type f, logic last);
      send_entry_type e;
      e.kind    = SEND_POINT;
      e.x_value = x;
      e.f_value = f;
      e.is_last = last;
      point_queue.push_back(e);
      points_built++;
      if (last)
         runs_built++;
   endtask

   task automatic add_marker(send_kind_type kind, int count);
      send_entry_type e;
      e.kind    = kind;
      e.x_value = '0;
      e.f_value = '0;
      e.is_last = 1'b0;
      for (int i = 0; i < count; i++)
         point_queue.push_back(e);
   endtask

   function automatic fdd_pkg::data_type small_word();
      fdd_pkg::data_type d;
      d = $urandom_range(0, 32'h0080_0000);
      return d - 32'sh0040_0000;
   endfunction

   function automatic fdd_pkg::data_type corner_word();
      case ($urandom_range(0, 5))
         0:       return fdd_pkg::DATA_MIN;
         1:       return fdd_pkg::DATA_MAX;
         2:       return '0;
         3:       return -1;
         4:       return 1;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_run(int len, int idle_pct);
      int                style;
      fdd_pkg::data_type x, f, dx;
      style = $urandom_range(0, 9);
      x     = small_word();
      f     = small_word();
      dx    = $urandom_range(1, 32'h0002_0000);
      if (style == 1)
         dx = -dx;
      for (int i = 0; i < len; i++) begin
         if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            add_marker(SEND_GAP, $urandom_range(1, 5));
         case (style)
            5, 6: begin
               x = $urandom;
               f = $urandom;
            end
            7: begin
               x = corner_word();
               f = corner_word();
            end
            8, 9: begin
               // tiny steps against wide swings: clipping and zero widths
               x = x + $urandom_range(0, 3);
               f = $urandom;
            end
            default: begin
               if (i > 0)
                  x = x + (($urandom_range(0, 15) == 0) ? 32'sd0 : dx);
               f = f + small_word();
            end
         endcase
         add_point(x, f, i == len - 1);
      end
   endtask

   // request side: hold a request until taken, then pull the next entry
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.x_value <= '0;
         req_if.f_value <= '0;
         req_if.is_last <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            take_point(req_if.x_value, req_if.f_value, req_if.is_last);
            points_sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (point_queue.size() == 0) begin
               req_if.valid <= 1'b0;
            end else if (point_queue[0].kind == SEND_DRAIN && slope_queue.size() != 0) begin
               req_if.valid <= 1'b0;
            end else begin
               head = point_queue.pop_front();
               if (head.kind == SEND_POINT) begin
                  req_if.valid   <= 1'b1;
                  req_if.x_value <= head.x_value;
                  req_if.f_value <= head.f_value;
                  req_if.is_last <= head.is_last;
               end else begin
                  req_if.valid <= 1'b0;
               end
            end
         end
      end
   end

   task automatic check_slope();
      fdd_pkg::result_type want;
      if (slope_queue.size() == 0) begin
         report_mismatch($sformatf("unexpected response slope=%0d err=%b sat=%b end=%b",
                                   rsp_if.slope, rsp_if.error, rsp_if.saturated,
                                   rsp_if.end_of_run));
      end else begin
         want = slope_queue.pop_front();
         if (rsp_if.slope !== want.slope)
            report_mismatch($sformatf("slope %0d, expected %0d", rsp_if.slope, want.slope));
         if (rsp_if.error !== want.error)
            report_mismatch($sformatf("error %b, expected %b", rsp_if.error, want.error));
         if (rsp_if.saturated !== want.saturated)
            report_mismatch($sformatf("saturated %b, expected %b", rsp_if.saturated,
                                      want.saturated));
         if (rsp_if.end_of_run !== want.end_of_run)
            report_mismatch($sformatf("end_of_run %b, expected %b", rsp_if.end_of_run,
                                      want.end_of_run));
         slopes_checked++;
         if (want.error)
            flagged_count++;
         if (want.saturated)
            clipped_count++;
      end
   endtask

   // response side: check, then stall in bursts whose odds are redrawn periodically
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            check_slope();
         monitor_cycles++;
         if (monitor_cycles % 300 == 0)
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 10;
               default: stall_pct = 35;
            endcase
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (point_queue.size() > TAIL_POINTS &&
                      $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 4);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      int target, len, idle_pct;
      reset = 1'b1;

      // single-point runs, plain and at the extremes
      add_point(0, 0, 1'b1);
      add_point(fdd_pkg::DATA_MAX, fdd_pkg::DATA_MIN, 1'b1);
      // two points, unit slope
      add_point(0, 0, 1'b0);
      add_point(ONE, ONE, 1'b1);
      // repeated abscissa
      add_point(5, 7, 1'b0);
      add_point(5, 100, 1'b1);
      // clip high, then clip low
      add_point(0, fdd_pkg::DATA_MIN, 1'b0);
      add_point(1, fdd_pkg::DATA_MAX, 1'b1);
      add_point(0, fdd_pkg::DATA_MAX, 1'b0);
      add_point(1, fdd_pkg::DATA_MIN, 1'b1);
      // land exactly on the range limits without clipping
      add_point(0, 0, 1'b0);
      add_point(ONE, fdd_pkg::DATA_MIN, 1'b1);
      add_point(0, 0, 1'b0);
      add_point(ONE, fdd_pkg::DATA_MAX, 1'b1);
      // widest abscissa span, central difference over a zero width
      add_point(fdd_pkg::DATA_MIN, 0, 1'b0);
      add_point(fdd_pkg::DATA_MAX, -1, 1'b0);
      add_point(fdd_pkg::DATA_MIN, 5, 1'b1);
      // quadratic table, interior points use central differences
      add_point(0, 0, 1'b0);
      add_point(ONE, ONE, 1'b0);
      add_point(2 * ONE, 4 * ONE, 1'b0);
      add_point(3 * ONE, 9 * ONE, 1'b0);
      add_point(4 * ONE, 16 * ONE, 1'b1);
      add_marker(SEND_DRAIN, 1);

      target = points_built + RANDOM_POINTS;
      while (points_built < target) begin
         case ($urandom_range(0, 9))
            0:       len = 1;
            1, 2, 3,
            4, 5, 6: len = $urandom_range(2, 6);
            default: len = $urandom_range(7, 40);
         endcase
         if (points_built + len > target)
            len = target - points_built;
         if (points_built + len > target - TAIL_POINTS - 20) begin
            idle_pct = 0;
         end else begin
            case ($urandom_range(0, 3))
               0, 1:    idle_pct = 0;
               2:       idle_pct = 15;
               default: idle_pct = 40;
            endcase
            if ($urandom_range(0, 19) == 0)
               add_marker(SEND_DRAIN, 1);
         end
         add_run(len, idle_pct);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (point_queue.size() != 0 || req_if.valid)
         @(posedge clock);
      while (slope_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d points in %0d runs, %0d derivatives checked,", points_sent,
               runs_built, slopes_checked);
      $display("of which %0d flagged as zero width or lone point and %0d clipped.",
               flagged_count, clipped_count);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timeout with %0d derivatives still outstanding.", slope_queue.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
